@@ design/i2cmbe_pkg.sv @@
// Package for the I2C master byte engine: opcodes, item/result/state
// structs, reset state and the per-phase line drive function.
// No dependencies.
`default_nettype none

package i2cmbe_pkg;

    typedef enum logic [1:0]
    {
        OP_TICK  = 2'd0,  // also the idle code of the active operation
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    localparam logic [3:0] DATA_BITS  = 4'd8;     // bit_count of the ACK bit
    localparam logic [3:0] STOP_SEG   = 4'd9;     // bit_count of the stop segment
    localparam logic [2:0] PHASE_HIGH = 3'd1;     // SCL-high phase of a bit
    localparam logic [2:0] PHASE_LAST = 3'd2;     // last phase of start / stop
    localparam logic [7:0] MSB_MASK   = 8'h80;

    typedef struct packed
    {
        op_t        opcode;
        logic [7:0] data_byte;
        logic       with_start;
        logic       with_stop;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed
    {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       ack_received;
        logic [7:0] read_value;
    } res_t;

    typedef struct packed
    {
        logic [2:0] phase_step;
        logic [3:0] bit_count;
        logic [7:0] shift_reg;
        op_t        active_op;
        logic       start_pending;
        logic       stop_pending;
        logic       ack_to_send;
        logic       scl_level;
        logic       sda_level;
        logic       ack_flag;
        logic [7:0] read_result;
    } st_t;

    localparam st_t ST_RESET = '{
        phase_step:    3'd0,
        bit_count:     4'd0,
        shift_reg:     8'h00,
        active_op:     OP_TICK,
        start_pending: 1'b0,
        stop_pending:  1'b0,
        ack_to_send:   1'b0,
        scl_level:     1'b1,
        sda_level:     1'b1,
        ack_flag:      1'b0,
        read_result:   8'h00
    };

    // Line levels for the phase the state points at.
    function automatic st_t drive_phase(st_t s);
        st_t  r;
        logic d;
        r = s;
        d = 1'b1;
        if (s.start_pending)
        begin
            r.scl_level = (s.phase_step < PHASE_LAST);
            r.sda_level = (s.phase_step == 3'd0);
        end
        else if (s.bit_count >= STOP_SEG)
        begin
            r.scl_level = (s.phase_step >= PHASE_HIGH);
            r.sda_level = (s.phase_step >= PHASE_LAST);
        end
        else
        begin
            if (s.active_op == OP_WRITE && s.bit_count < DATA_BITS)
            begin
                d = |(s.shift_reg & MSB_MASK);
            end
            else if (s.active_op == OP_READ && s.bit_count == DATA_BITS)
            begin
                d = !s.ack_to_send;
            end
            r.scl_level = (s.phase_step == PHASE_HIGH);
            r.sda_level = d;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/i2cmbe_in_stage.sv @@
// Input register stage of the I2C master byte engine.
// Depends on i2cmbe_pkg (item_t).
`default_nettype none

module i2cmbe_in_stage
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire i2cmbe_pkg::item_t   item_in,
    input  wire logic                take,
    output      logic                item_vld,
    output      i2cmbe_pkg::item_t   item_out
);

    logic              vld_reg;
    logic              vld_next;
    i2cmbe_pkg::item_t item_reg;

    assign in_ready = !vld_reg || take;
    assign item_vld = vld_reg;
    assign item_out = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (take)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

endmodule

`default_nettype wire

@@ design/i2cmbe_engine.sv @@
// Bus sequencer of the I2C master byte engine: state registers and the
// one-step next-state logic. Depends on i2cmbe_pkg.
`default_nettype none

module i2cmbe_engine
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step_en,
    input  wire i2cmbe_pkg::item_t   item,
    output      i2cmbe_pkg::res_t    res,
    output      i2cmbe_pkg::st_t     st_view
);

    i2cmbe_pkg::st_t st_reg;
    i2cmbe_pkg::st_t st_next;
    logic            done;

    always_comb
    begin
        st_next = st_reg;
        done    = 1'b0;
        if (st_reg.active_op == i2cmbe_pkg::OP_TICK)
        begin
            if (item.opcode != i2cmbe_pkg::OP_TICK)
            begin
                // load a new command and drive its first phase
                st_next.active_op     = item.opcode;
                st_next.phase_step    = 3'd0;
                st_next.bit_count     = (item.opcode == i2cmbe_pkg::OP_STOP)
                                        ? i2cmbe_pkg::STOP_SEG : 4'd0;
                st_next.start_pending = (item.opcode == i2cmbe_pkg::OP_WRITE)
                                        && item.with_start;
                st_next.stop_pending  = (item.opcode != i2cmbe_pkg::OP_STOP)
                                        && item.with_stop;
                st_next.ack_to_send   = (item.opcode == i2cmbe_pkg::OP_READ)
                                        && item.send_ack;
                st_next.shift_reg     = (item.opcode == i2cmbe_pkg::OP_WRITE)
                                        ? item.data_byte : 8'h00;
                st_next = i2cmbe_pkg::drive_phase(st_next);
            end
        end
        else if (item.opcode == i2cmbe_pkg::OP_TICK)
        begin
            if (st_reg.start_pending)
            begin
                st_next.phase_step = st_reg.phase_step + 3'd1;
                if (st_reg.phase_step >= i2cmbe_pkg::PHASE_LAST)
                begin
                    st_next.start_pending = 1'b0;
                    st_next.phase_step    = 3'd0;
                    st_next.bit_count     = 4'd0;
                end
                st_next = i2cmbe_pkg::drive_phase(st_next);
            end
            else if (st_reg.bit_count >= i2cmbe_pkg::STOP_SEG)
            begin
                st_next.phase_step = st_reg.phase_step + 3'd1;
                if (st_reg.phase_step >= i2cmbe_pkg::PHASE_LAST)
                begin
                    // stop finished, lines stay released
                    if (st_reg.active_op == i2cmbe_pkg::OP_READ)
                    begin
                        st_next.read_result = st_reg.shift_reg;
                    end
                    st_next.active_op  = i2cmbe_pkg::OP_TICK;
                    st_next.phase_step = 3'd0;
                    done               = 1'b1;
                end
                else
                begin
                    st_next = i2cmbe_pkg::drive_phase(st_next);
                end
            end
            else if (st_reg.phase_step == i2cmbe_pkg::PHASE_HIGH)
            begin
                // end of SCL high: sample SDA
                if (st_reg.active_op == i2cmbe_pkg::OP_WRITE)
                begin
                    if (st_reg.bit_count == i2cmbe_pkg::DATA_BITS)
                    begin
                        st_next.ack_flag = !item.sda_in;
                    end
                    else
                    begin
                        st_next.shift_reg = {st_reg.shift_reg[6:0], 1'b0};
                    end
                end
                else if (st_reg.active_op == i2cmbe_pkg::OP_READ
                         && st_reg.bit_count < i2cmbe_pkg::DATA_BITS)
                begin
                    st_next.shift_reg = {st_reg.shift_reg[6:0], item.sda_in};
                end
                st_next.phase_step = 3'd0;
                st_next.bit_count  = st_reg.bit_count + 4'd1;
                if (st_reg.bit_count == i2cmbe_pkg::DATA_BITS
                    && !st_reg.stop_pending)
                begin
                    // end without stop: park SCL low, SDA as it was
                    if (st_reg.active_op == i2cmbe_pkg::OP_READ)
                    begin
                        st_next.read_result = st_next.shift_reg;
                    end
                    st_next.active_op = i2cmbe_pkg::OP_TICK;
                    st_next.scl_level = 1'b0;
                    done              = 1'b1;
                end
                else
                begin
                    st_next = i2cmbe_pkg::drive_phase(st_next);
                end
            end
            else
            begin
                st_next.phase_step = i2cmbe_pkg::PHASE_HIGH;
                st_next = i2cmbe_pkg::drive_phase(st_next);
            end
        end
    end

    always_comb
    begin
        res.scl_out      = st_next.scl_level;
        res.sda_out      = st_next.sda_level;
        res.busy_res     = (st_next.active_op != i2cmbe_pkg::OP_TICK);
        res.done_res     = done;
        res.ack_received = st_next.ack_flag;
        res.read_value   = st_next.read_result;
    end

    assign st_view = st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= i2cmbe_pkg::ST_RESET;
        end
        else if (step_en)
        begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

@@ design/i2cmbe_out_stage.sv @@
// Result register of the I2C master byte engine.
// Depends on i2cmbe_pkg (res_t).
`default_nettype none

module i2cmbe_out_stage
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire i2cmbe_pkg::res_t   res_in,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic               can_load,
    output      i2cmbe_pkg::res_t   res_out
);

    logic             vld_reg;
    logic             vld_next;
    i2cmbe_pkg::res_t res_reg;

    assign can_load  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign res_out   = res_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

@@ design/i2c_master_byte_engine_core.sv @@
// I2C master byte engine, top level. out_valid rises after input accept
// (input register, then sequencer step into the result register). Throughput:
// one item per cycle while out_ready does not stall; the single sequencer
// step per item is the only recurrence. Reset (rst_n low, async): idle, SCL
// and SDA released high, ack/read results cleared, both pipeline stages empty.
// Depends on i2cmbe_pkg, i2cmbe_in_stage, i2cmbe_engine, i2cmbe_out_stage.
`default_nettype none

module i2c_master_byte_engine_core
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // item channel
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire logic [1:0] opcode,
    input  wire logic [7:0] data_byte,
    input  wire logic       with_start,
    input  wire logic       with_stop,
    input  wire logic       send_ack,
    input  wire logic       sda_in,
    // result channel
    output      logic       out_valid,
    input  wire logic       out_ready,
    output      logic       scl_out,
    output      logic       sda_out,
    output      logic       busy_res,
    output      logic       done_res,
    output      logic       ack_received,
    output      logic [7:0] read_value
);

    i2cmbe_pkg::item_t item_in;
    i2cmbe_pkg::item_t item_q;
    logic              item_vld;
    logic              can_load;
    logic              step_en;
    i2cmbe_pkg::res_t  res_d;
    i2cmbe_pkg::res_t  res_q;
    i2cmbe_pkg::st_t   st_view;

    always_comb
    begin
        item_in.opcode     = i2cmbe_pkg::op_t'(opcode);
        item_in.data_byte  = data_byte;
        item_in.with_start = with_start;
        item_in.with_stop  = with_stop;
        item_in.send_ack   = send_ack;
        item_in.sda_in     = sda_in;
    end

    // A held item advances the sequencer once the result register can take
    // its result; the input register refills in that same cycle.
    assign step_en = item_vld && can_load;

    i2cmbe_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .item_in  (item_in),
        .take     (step_en),
        .item_vld (item_vld),
        .item_out (item_q)
    );

    // Sequencer: commands load only when idle, ticks advance one half-bit
    // phase; every item yields exactly one result.
    i2cmbe_engine u_eng
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_q),
        .res     (res_d),
        .st_view (st_view)
    );

    i2cmbe_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step_en),
        .res_in    (res_d),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .can_load  (can_load),
        .res_out   (res_q)
    );

    assign scl_out      = res_q.scl_out;
    assign sda_out      = res_q.sda_out;
    assign busy_res     = res_q.busy_res;
    assign done_res     = res_q.done_res;
    assign ack_received = res_q.ack_received;
    assign read_value   = res_q.read_value;

    // A completing item always leaves the engine idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> !busy_res)
        else $error("done reported while still busy");

    // Idle engine always rests at phase zero.
    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (st_view.active_op == i2cmbe_pkg::OP_TICK) |-> (st_view.phase_step == 3'd0))
        else $error("idle with nonzero phase");

    // Only a write can carry a start condition.
    a_start_write: assert property (@(posedge clk) disable iff (!rst_n)
        st_view.start_pending |-> (st_view.active_op == i2cmbe_pkg::OP_WRITE))
        else $error("start pending outside a write");

    // Phase counter never leaves the three-phase range.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> (st_view.phase_step <= i2cmbe_pkg::PHASE_LAST))
        else $error("phase out of range");

endmodule

`default_nettype wire
